FILE: design/assert_macros.svh
// Assertion macros shared by the frame parser RTL.
// Included by every module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ifp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame parser.
// No dependencies; imported by all parser modules.
`default_nettype none

package ifp_pkg;

    // Frame format constants.
    localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
    localparam logic [7:0]  SYNC_SECOND = 8'hA5;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam int          MIN_PAYLOAD = 76;

    // Field store geometry: two banks of up to 32 words each.
    localparam int FIELD_COUNT = 20;
    localparam int FIDX_W      = 5;
    localparam int MEM_AW      = FIDX_W + 1;
    localparam int MEM_DEPTH   = 1 << MEM_AW;

    // Event queue between the parser and the result emitter.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // One finished frame: CRC verdict and the bank that holds its fields.
    typedef struct packed {
        logic ok;
        logic bank;
    } t_evt;

    // Write port into the field store.
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [31:0]       data;
    } t_wr;

    // Bank release from the emitter once its last word has been read.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    // CRC-16/XMODEM update with one byte, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/ifp_front.sv
// Byte parser: sync hunt, header decode, CRC and field capture.
// Depends on ifp_pkg and assert_macros.svh; feeds ifp_queue and ifp_back.
`default_nettype none
`include "assert_macros.svh"

module ifp_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_q_full,
    output logic               o_push,
    output ifp_pkg::t_evt      o_evt,
    output ifp_pkg::t_wr       o_wr,
    input  wire ifp_pkg::t_rel i_rel
);
    import ifp_pkg::*;

    localparam int POS_W = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [6:0] {
        PH_SYNC1   = 7'b0000001,
        PH_SYNC2   = 7'b0000010,
        PH_LEN_LO  = 7'b0000100,
        PH_LEN_HI  = 7'b0001000,
        PH_CHK_LO  = 7'b0010000,
        PH_CHK_HI  = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [15:0]        r_crc, n_crc;
    logic [15:0]        r_len, n_len;
    logic [15:0]        r_chk, n_chk;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [23:0]        r_asm, n_asm;
    logic               r_wbank, n_wbank;
    logic [1:0]         r_busy, n_busy;

    logic               accept;
    logic [15:0]        crc_b;
    logic [15:0]        len_full;
    logic [POS_W-1:0]   pos_next;
    logic               len_bad;

    // A beat is held back when the queue is full or the write bank still drains.
    assign o_in_stall = i_q_full || r_busy[r_wbank];
    assign accept     = i_in_valid && !o_in_stall;
    assign crc_b      = crc16_byte(r_crc, i_rx_byte);
    assign len_full   = {i_rx_byte, r_len[7:0]};
    assign pos_next   = r_pos + 1'b1;
    assign len_bad    = (17'(len_full) < 17'(MIN_PAYLOAD)) ||
                        (17'(len_full) > 17'(MAX_PAYLOAD));

    // Next-state logic of the parser.
    always_comb begin
        n_phase = r_phase;
        n_crc   = r_crc;
        n_len   = r_len;
        n_chk   = r_chk;
        n_pos   = r_pos;
        n_asm   = r_asm;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        o_push  = 1'b0;
        o_evt   = '0;
        o_wr    = '0;

        // The emitter frees a bank after reading its last word.
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end

        if (accept) begin
            case (r_phase)
                PH_SYNC2: begin
                    if (i_rx_byte == SYNC_SECOND) begin
                        n_crc   = crc_b;
                        n_phase = PH_LEN_LO;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_rx_byte};
                    n_crc   = crc_b;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len = len_full;
                    n_crc = crc_b;
                    if (len_bad) begin
                        o_push  = 1'b1;
                        o_evt   = '{ok: 1'b0, bank: r_wbank};
                        n_phase = PH_SYNC1;
                    end else begin
                        n_phase = PH_CHK_LO;
                    end
                end
                PH_CHK_LO: begin
                    n_chk   = {8'h00, i_rx_byte};
                    n_phase = PH_CHK_HI;
                end
                PH_CHK_HI: begin
                    n_chk   = {i_rx_byte, r_chk[7:0]};
                    n_pos   = '0;
                    n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    // Capture: byte 0 and byte 3 alone, then whole words.
                    n_asm = {i_rx_byte, r_asm[23:8]};
                    if (r_pos == '0) begin
                        o_wr = '{en: 1'b1, addr: {r_wbank, FIDX_W'(0)},
                                 data: {24'h000000, i_rx_byte}};
                    end else if (17'(r_pos) == 17'd3) begin
                        o_wr = '{en: 1'b1, addr: {r_wbank, FIDX_W'(1)},
                                 data: {24'h000000, i_rx_byte}};
                    end else if ((17'(r_pos) < 17'(MIN_PAYLOAD)) && (r_pos[1:0] == 2'd3)) begin
                        o_wr = '{en: 1'b1, addr: {r_wbank, r_pos[6:2] + FIDX_W'(1)},
                                 data: {i_rx_byte, r_asm}};
                    end
                    n_crc = crc_b;
                    n_pos = pos_next;
                    // Frame end: report the CRC verdict and swap banks on success.
                    if (17'(pos_next) >= 17'(r_len)) begin
                        o_push  = 1'b1;
                        o_evt   = '{ok: (crc_b == r_chk), bank: r_wbank};
                        n_phase = PH_SYNC1;
                        if (crc_b == r_chk) begin
                            n_busy[r_wbank] = 1'b1;
                            n_wbank         = ~r_wbank;
                        end
                    end
                end
                default: begin
                    if (i_rx_byte == SYNC_FIRST) begin
                        n_crc   = crc16_byte(16'h0000, i_rx_byte);
                        n_phase = PH_SYNC2;
                    end else begin
                        n_crc   = 16'h0000;
                        n_phase = PH_SYNC1;
                    end
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_wbank <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            r_phase <= n_phase;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

    // Header and assembly registers; every frame rewrites them before use.
    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        r_len <= n_len;
        r_chk <= n_chk;
        r_pos <= n_pos;
        r_asm <= n_asm;
    end

    `AST_IMP(a_push_room, i_clk, i_rst_n, o_push, !i_q_full, "event pushed into a full queue")
    `AST_IMP(a_rel_busy, i_clk, i_rst_n, i_rel.valid, r_busy[i_rel.bank],
             "released bank was not busy")

endmodule

`default_nettype wire

FILE: design/ifp_queue.sv
// Small event queue between the parser and the result emitter.
// Depends on ifp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ifp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ifp_pkg::t_evt i_evt,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output ifp_pkg::t_evt      o_head
);
    import ifp_pkg::*;

    t_evt              r_q [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_q[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_evt;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `AST_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, !o_empty, "pop from an empty queue")

endmodule

`default_nettype wire

FILE: design/ifp_back.sv
// Result emitter: double-banked field store, read stage and output register.
// Depends on ifp_pkg and assert_macros.svh; drains events from ifp_queue.
`default_nettype none
`include "assert_macros.svh"

module ifp_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ifp_pkg::t_wr           i_wr,
    input  wire logic                   i_q_empty,
    input  wire ifp_pkg::t_evt          i_head,
    output logic                        o_pop,
    output ifp_pkg::t_rel               o_rel,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [ifp_pkg::FIDX_W-1:0]  o_field_index,
    output logic [31:0]                 o_field_value,
    output logic                        o_frame_ok,
    output logic                        o_last_of_frame
);
    import ifp_pkg::*;

    // Field store: bank bit on top, field index below.
    logic [31:0]       r_mem [0:MEM_DEPTH-1];
    logic [31:0]       r_rdata;

    // Event being walked.
    logic              r_act;
    logic              r_ok;
    logic              r_bank;
    logic [FIDX_W-1:0] r_idx;

    // Read stage.
    logic              r_a_valid;
    logic [FIDX_W-1:0] r_a_idx;
    logic              r_a_ok;
    logic              r_a_last;

    // Output register.
    logic              r_out_valid;
    logic [FIDX_W-1:0] r_out_idx;
    logic [31:0]       r_out_val;
    logic              r_out_ok;
    logic              r_out_last;

    logic              b_free;
    logic              adv_a;
    logic              issue;
    logic              issue_last;
    logic              rd_en;

    // Stage advance conditions.
    assign b_free     = !r_out_valid || !i_out_stall;
    assign adv_a      = !r_a_valid || b_free;
    assign issue      = r_act && adv_a;
    assign issue_last = !r_ok || (r_idx == FIDX_W'(FIELD_COUNT - 1));
    assign rd_en      = issue && r_ok;
    assign o_pop      = !r_act && !i_q_empty;
    assign o_rel      = '{valid: rd_en && issue_last, bank: r_bank};

    // Memory write from the parser and registered read for the emitter.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[{r_bank, r_idx}];
        end
    end

    // Event walker and stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (issue && issue_last) begin
                r_act <= 1'b0;
            end
            if (adv_a) begin
                r_a_valid <= issue;
            end
            if (b_free) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    // Walker payload and per-stage result fields.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok   <= i_head.ok;
            r_bank <= i_head.bank;
            r_idx  <= '0;
        end else if (issue && !issue_last) begin
            r_idx <= r_idx + 1'b1;
        end
        if (issue) begin
            r_a_idx  <= r_idx;
            r_a_ok   <= r_ok;
            r_a_last <= issue_last;
        end
        if (b_free && r_a_valid) begin
            r_out_idx  <= r_a_idx;
            r_out_val  <= r_a_ok ? r_rdata : 32'h0000_0000;
            r_out_ok   <= r_a_ok;
            r_out_last <= r_a_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_field_index   = r_out_idx;
    assign o_field_value   = r_out_val;
    assign o_frame_ok      = r_out_ok;
    assign o_last_of_frame = r_out_last;

    `AST_IMP(a_last_idx, i_clk, i_rst_n, r_out_valid && r_out_ok,
             r_out_last == (r_out_idx == FIDX_W'(FIELD_COUNT - 1)),
             "last marker does not match the final field")
    `AST_IMP(a_err_shape, i_clk, i_rst_n, r_out_valid && !r_out_ok,
             r_out_last && (r_out_idx == '0) && (r_out_val == '0),
             "error beat carries field data")
    `AST_NEXT(a_rd_hold, i_clk, i_rst_n, r_a_valid && !adv_a, $stable(r_rdata),
              "read data changed while the read stage was held")

endmodule

`default_nettype wire

FILE: design/imu_frame_parser_crc16_top.sv
// Channel  Direction  Handshake                 Beat payload
// input    in         i_in_valid / o_in_stall   i_rx_byte
// output   out        o_out_valid / i_out_stall o_field_index, o_field_value,
//                                               o_frame_ok, o_last_of_frame
//
// One byte is accepted per cycle unless the input stalls; CRC update and field
// capture finish in that cycle. A good frame yields 20 beats at one per cycle
// unless the output stalls, an error yields one beat; each event passes through
// the queue, walker, read stage and output register. Reset is synchronous.
// The input stalls when the 4-entry event queue is full or both field banks are
// still waiting to drain; a stalled output holds its beat and the read stage.
//
// Top level of the frame parser; depends on ifp_pkg, ifp_front, ifp_queue, ifp_back.
`default_nettype none

module imu_frame_parser_crc16_top #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_rx_byte,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [ifp_pkg::FIDX_W-1:0]  o_field_index,
    output logic [31:0]                 o_field_value,
    output logic                        o_frame_ok,
    output logic                        o_last_of_frame
);
    import ifp_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_evt evt;
    t_evt head;
    t_wr  wr;
    t_rel rel;

    // Parser front.
    ifp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_evt      (evt),
        .o_wr       (wr),
        .i_rel      (rel)
    );

    // Frame event queue.
    ifp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (evt),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // Result emitter.
    ifp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (wr),
        .i_q_empty       (q_empty),
        .i_head          (head),
        .o_pop           (pop),
        .o_rel           (rel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_field_index   (o_field_index),
        .o_field_value   (o_field_value),
        .o_frame_ok      (o_frame_ok),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire
